// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: field widths, fixed-point constants,
// sector codes and the hue position struct. Depends on nothing.
`default_nettype none

package hsv2rgb_pkg;

   localparam int unsigned HUE_W    = 20;
   localparam int unsigned SAT_W    = 16;
   localparam int unsigned CHAN_W   = 16;
   localparam int unsigned SECTOR_W = 3;
   localparam int unsigned FRAC_W   = 10;
   localparam int unsigned TERM_W   = CHAN_W + FRAC_W;

   // Hue scale: 1/16 degree, so a full turn is 5760 and a sector is 960.
   localparam int unsigned HUE_TURN    = 5760;
   localparam int unsigned SECTOR_SPAN = 960;
   localparam int unsigned SAT_ONE     = 32768;
   localparam int unsigned SAT_FRAC_W  = 15;

   // 5760 = 45 * 128: hue / 5760 is (hue >> 7) / 45, estimated by a reciprocal.
   localparam int unsigned HUE_PRE_SHIFT   = 7;
   localparam int unsigned HUE_RECIP       = 1456;
   localparam int unsigned HUE_RECIP_SHIFT = 16;

   // 960 = 15 * 64: term / 960 is (term >> 6) / 15, estimated by a reciprocal.
   localparam int unsigned DIV_PRE_SHIFT   = 6;
   localparam int unsigned DIV_ODD         = 15;
   localparam int unsigned DIV_RECIP       = 1118481;
   localparam int unsigned DIV_RECIP_SHIFT = 24;

   // Sector codes, 60 degrees each.
   localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [FRAC_W-1:0]   frac;
   } hue_pos_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hsv2rgb_if.sv =====
// Valid/ready channel interfaces for the HSV to RGB converter.
// Depends on hsv2rgb_pkg for the field widths.
`default_nettype none

interface hsv2rgb_req_if;
   logic                             valid;
   logic                             ready;
   logic [hsv2rgb_pkg::HUE_W-1:0]    hue;
   logic [hsv2rgb_pkg::SAT_W-1:0]    saturation;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   red;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   green;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hsv2rgb_hue_split.sv =====
// Three-stage hue reduction: hue mod 5760, then sector and fraction.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_hue_split (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [hsv2rgb_pkg::HUE_W-1:0] hue_in,
   output hsv2rgb_pkg::hue_pos_type           pos_out
);

   // Stage 1: quotient estimate, exact or one low.
   logic [12:0] hue_hi;
   logic [23:0] q_prod;
   logic [7:0]  q_in, q_ff;
   logic [hsv2rgb_pkg::HUE_W-1:0] hue_ff;

   assign hue_hi = hue_in[hsv2rgb_pkg::HUE_W-1:hsv2rgb_pkg::HUE_PRE_SHIFT];
   assign q_prod = 24'(hue_hi) * 24'(hsv2rgb_pkg::HUE_RECIP);
   assign q_in   = q_prod[23:hsv2rgb_pkg::HUE_RECIP_SHIFT];

   // Stage 2: remainder with one correction step.
   logic [hsv2rgb_pkg::HUE_W-1:0] q_back;
   logic [13:0] rem_raw;
   logic [12:0] h_in, h_ff;

   assign q_back  = 20'(q_ff) * 20'(hsv2rgb_pkg::HUE_TURN);
   assign rem_raw = 14'(hue_ff - q_back);
   assign h_in    = (rem_raw >= 14'(hsv2rgb_pkg::HUE_TURN))
                    ? 13'(rem_raw - 14'(hsv2rgb_pkg::HUE_TURN)) : 13'(rem_raw);

   // Stage 3: sector by threshold compare, fraction by subtracting its base.
   hsv2rgb_pkg::hue_pos_type pos_in, pos_ff;
   logic [12:0] base;

   always_comb begin
      priority if (h_ff >= 13'(5 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         pos_in.sector = hsv2rgb_pkg::SECTOR_MAGENTA_RED;
         base          = 13'(5 * hsv2rgb_pkg::SECTOR_SPAN);
      end else if (h_ff >= 13'(4 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         pos_in.sector = hsv2rgb_pkg::SECTOR_BLUE_MAGENTA;
         base          = 13'(4 * hsv2rgb_pkg::SECTOR_SPAN);
      end else if (h_ff >= 13'(3 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         pos_in.sector = hsv2rgb_pkg::SECTOR_CYAN_BLUE;
         base          = 13'(3 * hsv2rgb_pkg::SECTOR_SPAN);
      end else if (h_ff >= 13'(2 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         pos_in.sector = hsv2rgb_pkg::SECTOR_GREEN_CYAN;
         base          = 13'(2 * hsv2rgb_pkg::SECTOR_SPAN);
      end else if (h_ff >= 13'(hsv2rgb_pkg::SECTOR_SPAN)) begin
         pos_in.sector = hsv2rgb_pkg::SECTOR_YELLOW_GREEN;
         base          = 13'(hsv2rgb_pkg::SECTOR_SPAN);
      end else begin
         pos_in.sector = hsv2rgb_pkg::SECTOR_RED_YELLOW;
         base          = 13'd0;
      end
      pos_in.frac = 10'(h_ff - base);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff   <= q_in;
         hue_ff <= hue_in;
         h_ff   <= h_in;
         pos_ff <= pos_in;
      end
   end

   assign pos_out = pos_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hsv2rgb_div960.sv =====
// Two-stage divide by 960 of the secondary product, truncating.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_div960 (
   input  wire logic                           clock,
   input  wire logic                           enable,
   input  wire logic [hsv2rgb_pkg::TERM_W-1:0] term_in,
   output logic      [hsv2rgb_pkg::CHAN_W-1:0] quot_out
);

   localparam int unsigned X_W = hsv2rgb_pkg::TERM_W - hsv2rgb_pkg::DIV_PRE_SHIFT;

   // Stage 1: divide by 64 is a shift, divide by 15 is a reciprocal estimate.
   logic [X_W-1:0] x_in, x_ff;
   logic [40:0]    q_prod;
   logic [hsv2rgb_pkg::CHAN_W-1:0] qe_in, qe_ff;

   assign x_in   = term_in[hsv2rgb_pkg::TERM_W-1:hsv2rgb_pkg::DIV_PRE_SHIFT];
   assign q_prod = 41'(x_in) * 41'(hsv2rgb_pkg::DIV_RECIP);
   assign qe_in  = q_prod[hsv2rgb_pkg::DIV_RECIP_SHIFT +: hsv2rgb_pkg::CHAN_W];

   // Stage 2: the estimate is exact or one low; check the remainder.
   logic [X_W-1:0] q_back, rem;
   logic [hsv2rgb_pkg::CHAN_W-1:0] quot_in, quot_ff;

   assign q_back  = X_W'(qe_ff) * X_W'(hsv2rgb_pkg::DIV_ODD);
   assign rem     = x_ff - q_back;
   assign quot_in = (rem >= X_W'(hsv2rgb_pkg::DIV_ODD)) ? qe_ff + 16'd1 : qe_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         qe_ff   <= qe_in;
         quot_ff <= quot_in;
      end
   end

   assign quot_out = quot_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hsv2rgb_to_rgb_converter_core.sv =====
// Top level of the HSV to RGB converter: pipeline control, chroma and
// secondary products, channel mapping. Depends on hsv2rgb_pkg, hsv2rgb_if,
// hsv2rgb_hue_split and hsv2rgb_div960.
`default_nettype none

// HSV to RGB pixel converter.
//
// Each beat on the req channel carries one pixel: hue in 1/16 degree units
// (any value, wrapped modulo 360 degrees), saturation in Q1.15 (values above
// 1.0 are treated as 1.0) and brightness in Q8.8. Each beat on the rsp
// channel carries red, green and blue in Q8.8, one result beat per request
// beat, in order. All products and quotients truncate.
//
// The pipeline has seven register stages. One pixel is accepted every
// clock cycle unless a waiting result is held up by rsp.ready low. The
// depth is set by the hue modulo (reciprocal estimate, correction, sector
// split), the chroma-by-fraction multiply and the divide by 960
// (reciprocal estimate, correction), each given its own stage.
//
// All stages advance together. When the receiver holds rsp.ready low with
// a result waiting, req.ready drops and the whole pipeline holds, bubbles
// included; nothing is lost or repeated. While the last stage is empty the
// pipeline advances whatever rsp.ready does. A synchronous reset clears
// all valid bits; data registers are not reset.
module hsv_to_rgb_converter_core (
   input  wire logic     clock,
   input  wire logic     reset,
   hsv2rgb_req_if.sink   req,
   hsv2rgb_rsp_if.source rsp
);

   localparam int unsigned STAGES = 7;

   logic              advance;
   logic [STAGES-1:0] valid_ff, valid_in;

   // The pipeline moves when its last stage is empty or being emptied.
   assign advance   = !valid_ff[STAGES-1] || rsp.ready;
   assign req.ready = advance;
   assign valid_in  = advance ? {valid_ff[STAGES-2:0], req.valid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: clamp saturation and form chroma = brightness * saturation.
   logic [hsv2rgb_pkg::SAT_W-1:0]  sat_clamped;
   logic [31:0]                    chroma_prod;
   logic [hsv2rgb_pkg::CHAN_W-1:0] chroma1_in, chroma1_ff, value1_ff;

   assign sat_clamped = (req.saturation > 16'(hsv2rgb_pkg::SAT_ONE))
                        ? 16'(hsv2rgb_pkg::SAT_ONE) : req.saturation;
   assign chroma_prod = 32'(req.brightness) * 32'(sat_clamped);
   assign chroma1_in  = chroma_prod[hsv2rgb_pkg::SAT_FRAC_W +: hsv2rgb_pkg::CHAN_W];

   // Hue reduction runs alongside in stages 1 to 3.
   hsv2rgb_pkg::hue_pos_type pos3;

   hsv2rgb_hue_split u_hue_split (
      .clock   (clock),
      .enable  (advance),
      .hue_in  (req.hue),
      .pos_out (pos3)
   );

   // Stage 2: offset = brightness - chroma, which never goes negative.
   logic [hsv2rgb_pkg::CHAN_W-1:0] chroma2_ff, offset2_in, offset2_ff;
   assign offset2_in = value1_ff - chroma1_ff;

   // Stage 3: chroma and offset wait for the hue position.
   logic [hsv2rgb_pkg::CHAN_W-1:0] chroma3_ff, offset3_ff;

   // Stage 4: secondary product, chroma times the fraction or its complement.
   logic [hsv2rgb_pkg::FRAC_W-1:0]   frac_sel;
   logic [hsv2rgb_pkg::TERM_W-1:0]   term4_in, term4_ff;
   logic [hsv2rgb_pkg::SECTOR_W-1:0] sector4_ff, sector5_ff, sector6_ff;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   chroma4_ff, chroma5_ff, chroma6_ff;
   logic [hsv2rgb_pkg::CHAN_W-1:0]   offset4_ff, offset5_ff, offset6_ff;

   assign frac_sel = pos3.sector[0]
                     ? 10'(hsv2rgb_pkg::SECTOR_SPAN - 32'(pos3.frac)) : pos3.frac;
   assign term4_in = 26'(chroma3_ff) * 26'(frac_sel);

   // Stages 5 and 6: divide the secondary product by 960.
   logic [hsv2rgb_pkg::CHAN_W-1:0] second6;

   hsv2rgb_div960 u_div960 (
      .clock    (clock),
      .enable   (advance),
      .term_in  (term4_ff),
      .quot_out (second6)
   );

   // Stage 7: map chroma and secondary onto the channels, then add offset.
   logic [hsv2rgb_pkg::CHAN_W-1:0] red_pre, green_pre, blue_pre;
   logic [hsv2rgb_pkg::CHAN_W-1:0] red_in, green_in, blue_in;
   logic [hsv2rgb_pkg::CHAN_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      unique case (sector6_ff)
         hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
            red_pre = chroma6_ff; green_pre = second6;    blue_pre = '0;
         end
         hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
            red_pre = second6;    green_pre = chroma6_ff; blue_pre = '0;
         end
         hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
            red_pre = '0;         green_pre = chroma6_ff; blue_pre = second6;
         end
         hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
            red_pre = '0;         green_pre = second6;    blue_pre = chroma6_ff;
         end
         hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
            red_pre = second6;    green_pre = '0;         blue_pre = chroma6_ff;
         end
         default: begin
            red_pre = chroma6_ff; green_pre = '0;         blue_pre = second6;
         end
      endcase
      red_in   = red_pre + offset6_ff;
      green_in = green_pre + offset6_ff;
      blue_in  = blue_pre + offset6_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chroma1_ff <= chroma1_in;
         value1_ff  <= req.brightness;
         chroma2_ff <= chroma1_ff;
         offset2_ff <= offset2_in;
         chroma3_ff <= chroma2_ff;
         offset3_ff <= offset2_ff;
         term4_ff   <= term4_in;
         sector4_ff <= pos3.sector;
         chroma4_ff <= chroma3_ff;
         offset4_ff <= offset3_ff;
         sector5_ff <= sector4_ff;
         chroma5_ff <= chroma4_ff;
         offset5_ff <= offset4_ff;
         sector6_ff <= sector5_ff;
         chroma6_ff <= chroma5_ff;
         offset6_ff <= offset5_ff;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
      end
   end

   assign rsp.valid = valid_ff[STAGES-1];
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;

   // A valid item leaving the hue split has a legal sector and fraction.
   a_hue_pos_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (pos3.sector <= hsv2rgb_pkg::SECTOR_MAGENTA_RED) &&
                      (32'(pos3.frac) < hsv2rgb_pkg::SECTOR_SPAN))
      else $error("hue split produced an out-of-range sector or fraction");

   // The secondary term never exceeds chroma after the divide.
   a_second_le_chroma: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> second6 <= chroma6_ff)
      else $error("secondary term exceeds chroma");

   // A waiting result that is not taken stops new pixels from entering.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input accepted while output stalled");

endmodule

`default_nettype wire

// ===== verif/hsv2rgb_color_checker.sv =====
`timescale 1ns / 1ps
// Pixel checker for the HSV to RGB converter: predicts each pixel's color
// at req acceptance and compares it with the rsp beats in order.
// Depends on hsv2rgb_pkg and hsv2rgb_if.

module hsv2rgb_color_checker (
   input  logic        clock,
   input  logic        reset,
   hsv2rgb_req_if      req,
   hsv2rgb_rsp_if      rsp,
   output int unsigned fail_count,
   output int unsigned pixels_pending,
   output int unsigned pixels_checked
);

   typedef struct packed {
      logic [hsv2rgb_pkg::CHAN_W-1:0] red;
      logic [hsv2rgb_pkg::CHAN_W-1:0] green;
      logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
   } rgb_pixel_type;

   rgb_pixel_type expected_colors[$];

   // Truncating fixed-point conversion, one pixel.
   function automatic rgb_pixel_type predict_rgb(
      input logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
      input logic [hsv2rgb_pkg::SAT_W-1:0]  saturation,
      input logic [hsv2rgb_pkg::CHAN_W-1:0] brightness);
      bit [31:0]                      sat_capped;
      bit [31:0]                      hue_wrapped;
      bit [31:0]                      frac;
      bit [31:0]                      chroma;
      bit [31:0]                      second;
      bit [31:0]                      offset;
      bit [31:0]                      r, g, b;
      bit [hsv2rgb_pkg::SECTOR_W-1:0] sector;
      rgb_pixel_type                  px;
      sat_capped  = (saturation > hsv2rgb_pkg::SAT_ONE)
                    ? hsv2rgb_pkg::SAT_ONE : 32'(saturation);
      hue_wrapped = 32'(hue) % hsv2rgb_pkg::HUE_TURN;
      sector      = hsv2rgb_pkg::SECTOR_W'(hue_wrapped / hsv2rgb_pkg::SECTOR_SPAN);
      frac        = hue_wrapped % hsv2rgb_pkg::SECTOR_SPAN;
      chroma      = (32'(brightness) * sat_capped) >> hsv2rgb_pkg::SAT_FRAC_W;
      // Odd sectors run the secondary term down instead of up.
      if (sector[0])
         second = (chroma * (hsv2rgb_pkg::SECTOR_SPAN - frac)) / hsv2rgb_pkg::SECTOR_SPAN;
      else
         second = (chroma * frac) / hsv2rgb_pkg::SECTOR_SPAN;
      offset = 32'(brightness) - chroma;
      case (sector)
         hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
            r = chroma; g = second; b = 0;
         end
         hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
            r = second; g = chroma; b = 0;
         end
         hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
            r = 0; g = chroma; b = second;
         end
         hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
            r = 0; g = second; b = chroma;
         end
         hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
            r = second; g = 0; b = chroma;
         end
         default: begin
            r = chroma; g = 0; b = second;
         end
      endcase
      px.red   = hsv2rgb_pkg::CHAN_W'(r + offset);
      px.green = hsv2rgb_pkg::CHAN_W'(g + offset);
      px.blue  = hsv2rgb_pkg::CHAN_W'(b + offset);
      return px;
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         expected_colors.delete();
         fail_count     = 0;
         pixels_pending = 0;
         pixels_checked = 0;
      end else begin
         // A result beat always belongs to an older pixel, so check before queuing.
         if (rsp.valid && rsp.ready) begin
            if (expected_colors.size() == 0) begin
               $error("unexpected result beat: red %h green %h blue %h",
                      rsp.red, rsp.green, rsp.blue);
               fail_count++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp.red !== want.red) begin
                  $error("pixel %0d red: expected %h, actual %h",
                         pixels_checked, want.red, rsp.red);
                  fail_count++;
               end
               if (rsp.green !== want.green) begin
                  $error("pixel %0d green: expected %h, actual %h",
                         pixels_checked, want.green, rsp.green);
                  fail_count++;
               end
               if (rsp.blue !== want.blue) begin
                  $error("pixel %0d blue: expected %h, actual %h",
                         pixels_checked, want.blue, rsp.blue);
                  fail_count++;
               end
               pixels_checked++;
            end
         end
         if (req.valid && req.ready)
            expected_colors.push_back(predict_rgb(req.hue, req.saturation, req.brightness));
         pixels_pending = expected_colors.size();
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the HSV to RGB converter testbench: clock, reset, pixel stimulus,
// output back-pressure and the final verdict.
// Depends on hsv2rgb_pkg, hsv2rgb_if, the converter core and hsv2rgb_color_checker.

module testbench;

   localparam int          CLOCK_PERIOD_NS = 2;
   localparam int          RESET_CYCLES    = 8;
   // Cycle limit for the whole run, set far above the slowest legal run for a wide margin.
   localparam int          LIMIT_CYCLES    = 400_000;
   localparam int          HOLD_CYCLES     = 80;
   localparam int          DRAIN_CYCLES    = 20;
   localparam int unsigned RANDOM_PIXELS   = 500;

   logic clock;
   logic reset;

   hsv2rgb_req_if pixel_in ();
   hsv2rgb_rsp_if pixel_out ();

   int unsigned fail_count;
   int unsigned pixels_pending;
   int unsigned pixels_checked;
   int unsigned pixels_sent;

   // Pacing controls for the pixel source and the output receiver.
   bit free_flow_in;
   bit free_flow_out;
   bit hold_output_request;

   hsv_to_rgb_converter_core dut (
      .clock (clock),
      .reset (reset),
      .req   (pixel_in),
      .rsp   (pixel_out)
   );

   hsv2rgb_color_checker color_check (
      .clock          (clock),
      .reset          (reset),
      .req            (pixel_in),
      .rsp            (pixel_out),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending),
      .pixels_checked (pixels_checked)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD_NS / 2) clock = ~clock;
   end

   // Hard stop in case the pipeline wedges and a handshake never completes.
   initial begin
      #(CLOCK_PERIOD_NS * LIMIT_CYCLES);
      $display("Verification failed");
      $finish;
   end

   // Idle stretch length: about half the time none, mostly short otherwise,
   // and now and then a long one so that gaps land on every pipeline stage.
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Output receiver. It runs in its own process so that the long hold-off is
   // counted here while the pixel source keeps pushing beats into the block.
   initial begin
      int unsigned stall_left;
      stall_left      = 0;
      pixel_out.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output_request) begin
            hold_output_request = 1'b0;
            pixel_out.ready     = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            pixel_out.ready = 1'b1;
         end else if (free_flow_out) begin
            pixel_out.ready = 1'b1;
         end else if (stall_left != 0) begin
            pixel_out.ready = 1'b0;
            stall_left--;
         end else begin
            stall_left      = idle_length();
            pixel_out.ready = (stall_left == 0);
            if (stall_left != 0)
               stall_left--;
         end
      end
   end

   // Offers one pixel beat, after an optional idle gap, and returns at the
   // falling edge after it was accepted. Valid is left high so that the next
   // call can follow back to back without a bubble.
   task automatic send_pixel(input logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
                             input logic [hsv2rgb_pkg::SAT_W-1:0]  saturation,
                             input logic [hsv2rgb_pkg::CHAN_W-1:0] brightness);
      int unsigned idle;
      idle = free_flow_in ? 0 : idle_length();
      if (idle != 0) begin
         pixel_in.valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      pixel_in.valid      = 1'b1;
      pixel_in.hue        = hue;
      pixel_in.saturation = saturation;
      pixel_in.brightness = brightness;
      @(posedge clock);
      while (!pixel_in.ready) @(posedge clock);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Random pixel. Hue mostly covers the whole 20-bit field, so wrapping is
   // common, with some weight on one turn and on sector boundaries.
   // Saturation leans toward the legal range but also goes past 1.0 so the
   // cap is exercised, and brightness sometimes sits at full scale or near zero.
   task automatic send_random_pixel();
      logic [hsv2rgb_pkg::HUE_W-1:0]  hue;
      logic [hsv2rgb_pkg::SAT_W-1:0]  saturation;
      logic [hsv2rgb_pkg::CHAN_W-1:0] brightness;
      int unsigned                    roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, (1 << hsv2rgb_pkg::HUE_W) - 1));
      else if (roll < 90)
         hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, hsv2rgb_pkg::HUE_TURN - 1));
      else
         hue = hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_SPAN * $urandom_range(1, 6)
                                   + $urandom_range(0, 2) - 1);
      roll = $urandom_range(0, 99);
      if (roll < 60)
         saturation = hsv2rgb_pkg::SAT_W'($urandom_range(0, hsv2rgb_pkg::SAT_ONE));
      else if (roll < 75)
         saturation = hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE);
      else
         saturation = hsv2rgb_pkg::SAT_W'($urandom_range(0, (1 << hsv2rgb_pkg::SAT_W) - 1));
      roll = $urandom_range(0, 99);
      if (roll < 85)
         brightness = hsv2rgb_pkg::CHAN_W'($urandom_range(0, (1 << hsv2rgb_pkg::CHAN_W) - 1));
      else if (roll < 95)
         brightness = '1;
      else
         brightness = hsv2rgb_pkg::CHAN_W'($urandom_range(0, 255));
      send_pixel(hue, saturation, brightness);
   endtask

   // Holds off until every predicted pixel has been seen on the output.
   task automatic wait_for_drain();
      while (pixels_pending != 0) @(negedge clock);
   endtask

   initial begin
      reset               = 1'b1;
      pixel_in.valid      = 1'b0;
      pixel_in.hue        = '0;
      pixel_in.saturation = '0;
      pixel_in.brightness = '0;
      pixels_sent         = 0;
      free_flow_in        = 1'b0;
      free_flow_out       = 1'b0;
      hold_output_request = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pixels. Full saturation and full brightness at the start of
      // every sector show the channel mapping in its cleanest form.
      for (int s = 0; s < 6; s++)
         send_pixel(hsv2rgb_pkg::HUE_W'(s * hsv2rgb_pkg::SECTOR_SPAN),
                    hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE), '1);
      // Last step of an even sector and of an odd sector, where the
      // secondary term is at its largest and at its smallest.
      send_pixel(hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_SPAN - 1),
                 hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE), '1);
      send_pixel(hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_SPAN - 1),
                 hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE), '1);
      // Hue wrapping: just below a full turn, exactly one turn, the largest
      // field value and a hue many turns around.
      send_pixel(hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_TURN - 1),
                 hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE), 16'hC000);
      send_pixel(hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_TURN),
                 hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE), 16'hC000);
      send_pixel('1, 16'h6000, 16'hFFFF);
      send_pixel(hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_TURN * 100 + 1234), 16'h4000, 16'h8000);
      // Saturation: gray, just below 1.0, just above 1.0 and the field maximum.
      send_pixel(hsv2rgb_pkg::HUE_W'(1500), 16'h0000, 16'h7F80);
      send_pixel(hsv2rgb_pkg::HUE_W'(1500), 16'h7FFF, 16'hFFFF);
      send_pixel(hsv2rgb_pkg::HUE_W'(1500), 16'h8001, 16'hFFFF);
      send_pixel(hsv2rgb_pkg::HUE_W'(4000), 16'hFFFF, 16'hFFFF);
      // Brightness: black, the smallest step and half scale.
      send_pixel(hsv2rgb_pkg::HUE_W'(3000), hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE), 16'h0000);
      send_pixel(hsv2rgb_pkg::HUE_W'(3000), hsv2rgb_pkg::SAT_W'(hsv2rgb_pkg::SAT_ONE), 16'h0001);
      send_pixel(hsv2rgb_pkg::HUE_W'(5000), 16'h2000, 16'h8000);
      // Alternating bit patterns so every input bit toggles both ways.
      send_pixel(20'hAAAAA, 16'h5555, 16'hAAAA);
      send_pixel(20'h55555, 16'hAAAA, 16'h5555);
      pixel_in.valid = 1'b0;
      wait_for_drain();

      // Random pixels with random gaps on both sides.
      repeat (RANDOM_PIXELS * 2 / 5) send_random_pixel();

      // A stretch at full rate on both sides, one pixel per clock.
      free_flow_in  = 1'b1;
      free_flow_out = 1'b1;
      repeat (RANDOM_PIXELS / 5) send_random_pixel();

      // Output held off for a long stretch while pixels keep coming at full
      // rate: the pipeline fills and req.ready must drop without losing or
      // repeating a beat.
      free_flow_out       = 1'b0;
      hold_output_request = 1'b1;
      repeat (40) send_random_pixel();
      free_flow_in   = 1'b0;
      pixel_in.valid = 1'b0;
      // The source now goes quiet until every pixel has come out.
      wait_for_drain();

      repeat (RANDOM_PIXELS - RANDOM_PIXELS * 3 / 5 - 40) send_random_pixel();
      pixel_in.valid = 1'b0;

      // Let the output run freely, wait for the last pixels, then give the
      // seven-stage pipeline time to show any stray extra beat.
      free_flow_out = 1'b1;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Converted %0d pixels and checked %0d colors: all six sectors, hue wrap,",
               pixels_sent, pixels_checked);
      $display("saturation cap, black and full scale, random gaps and a long output stall.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_if.sv
hw/rtl/hsv2rgb_hue_split.sv
hw/rtl/hsv2rgb_div960.sv
hw/rtl/hsv2rgb_to_rgb_converter_core.sv
verif/hsv2rgb_color_checker.sv
verif/testbench.sv
